// ----- hdl/mary_ask_fsk_psk_modulator_unit_assert.svh -----
// Assertion macros shared by the modulator RTL.
// Needs clk and arst_n in the scope of the module that expands them.
`ifndef MARY_ASK_FSK_PSK_MODULATOR_UNIT_ASSERT_SVH
`define MARY_ASK_FSK_PSK_MODULATOR_UNIT_ASSERT_SVH

// Condition and outcome in the same cycle.
`define MARY_CHECK_NOW(lbl, cond, outcome, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond) |-> (outcome)) \
		else $error(msg);

// Outcome in the cycle after the condition.
`define MARY_CHECK_NEXT(lbl, cond, outcome, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond) |=> (outcome)) \
		else $error(msg);

`endif

// ----- hdl/mary_pkg.sv -----
// Shared types and constants of the M-ary ASK/FSK/PSK modulator.
// No dependencies.
package mary_pkg;

	// modulation codes
	localparam logic [1:0] MODE_ASK = 2'd0;
	localparam logic [1:0] MODE_FSK = 2'd1;
	localparam logic [1:0] MODE_PSK = 2'd2;

	// configuration register indexes
	localparam logic [2:0] REG_MOD_MODE          = 3'd0;
	localparam logic [2:0] REG_BITS_PER_SYMBOL   = 3'd1;
	localparam logic [2:0] REG_SAMPLES_PER_SYMBOL = 3'd2;
	localparam logic [2:0] REG_CARRIER_PHASE_INC = 3'd3;
	localparam logic [2:0] REG_FSK_STEP_INC      = 3'd4;

	localparam logic [2:0] BPS_MIN = 3'd1;
	localparam logic [2:0] BPS_MAX = 3'd4;
	localparam logic [6:0] SPS_MIN = 7'd1;
	localparam logic [6:0] SPS_MAX = 7'd64;
	localparam int unsigned SPS_CNT_W = 6;

	localparam int unsigned FIFO_DEPTH = 4;

	// odd degree-9 sine polynomial, Q30, highest order last
	typedef logic signed [32:0] coef_t;
	localparam coef_t POLY_COEF [0:4] = '{
		33'sd1686629713, 33'sd693598668, 33'sd85569306, 33'sd5026995, 33'sd172271
	};

	typedef enum logic [1:0] {
		KIND_SINE,
		KIND_ASK,
		KIND_ZERO
	} kind_t;

	// clamped configuration as seen by the datapath
	typedef struct packed {
		logic [1:0]  mode;
		logic [2:0]  bps;
		logic [6:0]  sps;
		logic [31:0] carrier_inc;
		logic [31:0] fsk_inc;
	} mcfg_t;

	// one completed symbol in the queue
	typedef struct packed {
		logic [3:0] sym;
		logic       last;
	} sym_entry_t;

	// per-sample sideband through the sine pipeline
	typedef struct packed {
		logic [3:0] sym;
		logic       los;
		logic       lom;
		kind_t      kind;
	} side_t;

endpackage

// ----- hdl/mary_ifs.sv -----
// Valid/ready channel interfaces of the modulator: bits in, samples out, config writes.
// No dependencies.
interface mary_bit_if;
	logic valid;
	logic ready;
	logic message_bit;
	logic last_bit;
	modport source (output valid, message_bit, last_bit, input ready);
	modport sink (input valid, message_bit, last_bit, output ready);
endinterface

interface mary_smp_if;
	logic               valid;
	logic               ready;
	logic signed [19:0] sample;
	logic [3:0]         symbol_value;
	logic               last_of_symbol;
	logic               last_of_message;
	modport source (output valid, sample, symbol_value, last_of_symbol, last_of_message,
		input ready);
	modport sink (input valid, sample, symbol_value, last_of_symbol, last_of_message,
		output ready);
endinterface

interface mary_cfg_if;
	logic        valid;
	logic        ready;
	logic [2:0]  index;
	logic [31:0] data;
	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

// ----- hdl/mary_front.sv -----
// Front end: packs message bits MSB first into symbols and pushes them to the queue.
// Depends on mary_pkg and mary_ifs.
module mary_front (
	input  logic               clk,
	input  logic               arst_n,
	mary_bit_if.sink           bits,
	input  mary_pkg::mcfg_t    cfg,
	input  logic               q_full,
	output logic               q_push,
	output mary_pkg::sym_entry_t q_data
);

	logic [3:0] gather_q;
	logic [2:0] cnt_q;
	logic [3:0] gather_next;
	logic [2:0] cnt_next;
	logic [2:0] pad;
	logic [3:0] mask;
	logic       done;
	logic       accept;

	assign bits.ready = !q_full;
	assign accept     = bits.valid && bits.ready;

	always_comb begin
		gather_next = {gather_q[2:0], bits.message_bit};
		cnt_next    = cnt_q + 3'd1;
		done        = (cnt_next >= cfg.bps) || bits.last_bit;
		pad         = (cnt_next < cfg.bps) ? (cfg.bps - cnt_next) : 3'd0;
		mask        = 4'((5'd1 << cfg.bps) - 5'd1);
		q_data.sym  = 4'(gather_next << pad) & mask;
		q_data.last = bits.last_bit;
	end

	assign q_push = accept && done;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gather_q <= '0;
			cnt_q    <= '0;
		end else if (accept) begin
			// drop the gathered bits once a symbol leaves
			gather_q <= done ? 4'd0 : gather_next;
			cnt_q    <= done ? 3'd0 : cnt_next;
		end
	end

endmodule

// ----- hdl/mary_fifo.sv -----
// Short symbol queue between the bit packer and the sample generator.
// Depends on mary_pkg.
module mary_fifo (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	input  mary_pkg::sym_entry_t push_data,
	output logic                 full,
	input  logic                 pop,
	output mary_pkg::sym_entry_t pop_data,
	output logic                 not_empty
);

	localparam int unsigned PTR_W = $clog2(mary_pkg::FIFO_DEPTH);

	mary_pkg::sym_entry_t mem_q [0:mary_pkg::FIFO_DEPTH-1];
	logic [PTR_W-1:0] wr_q;
	logic [PTR_W-1:0] rd_q;
	logic [PTR_W:0]   count_q;

	assign full      = (count_q == (PTR_W+1)'(mary_pkg::FIFO_DEPTH));
	assign not_empty = (count_q != '0);
	assign pop_data  = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_q <= wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= rd_q + 1'b1;
			end
			count_q <= count_q + (PTR_W+1)'(push) - (PTR_W+1)'(pop);
		end
	end

endmodule

// ----- hdl/mary_back.sv -----
// Back end sequencer: takes symbols from the queue and issues one phase per sample.
// Depends on mary_pkg and the assertion macro header.
`include "mary_ask_fsk_psk_modulator_unit_assert.svh"

module mary_back (
	input  logic                 clk,
	input  logic                 arst_n,
	input  mary_pkg::mcfg_t      cfg,
	input  logic                 q_valid,
	input  mary_pkg::sym_entry_t q_data,
	output logic                 q_pop,
	input  logic                 adv,
	output logic                 vld_s1,
	output logic [31:0]          phase_s1,
	output mary_pkg::side_t      side_s1
);

	localparam int unsigned CW = mary_pkg::SPS_CNT_W;

	logic          busy_q;
	logic [CW-1:0] j_q;
	logic [3:0]    sym_q;
	logic          mlast_q;
	logic [31:0]   acc_q;
	logic [31:0]   inc_q;
	logic [31:0]   ask_phase_q;

	logic          emit;
	logic          last_smp;
	logic [31:0]   step;
	logic [31:0]   inc_new;
	logic [31:0]   off_new;
	mary_pkg::kind_t kind;

	assign last_smp = (7'(j_q) + 7'd1 == cfg.sps);
	assign emit     = adv && busy_q;
	assign q_pop    = adv && q_valid && (!busy_q || last_smp);

	always_comb begin
		step    = 32'({1'b0, q_data.sym[3:1]} + 4'd1) * cfg.fsk_inc;
		inc_new = cfg.carrier_inc;
		off_new = '0;
		if (cfg.mode == mary_pkg::MODE_FSK) begin
			inc_new = q_data.sym[0] ? cfg.carrier_inc + step : cfg.carrier_inc - step;
		end else if (cfg.mode == mary_pkg::MODE_PSK) begin
			case (cfg.bps)
				3'd1: off_new = {q_data.sym[0], 31'd0};
				3'd2: off_new = 32'({q_data.sym, 1'b1}) << 29;
				3'd3: off_new = 32'({q_data.sym, 1'b1}) << 28;
				3'd4: off_new = 32'({q_data.sym, 1'b1}) << 27;
				default: off_new = '0;
			endcase
		end
		case (cfg.mode)
			mary_pkg::MODE_ASK: kind = mary_pkg::KIND_ASK;
			mary_pkg::MODE_FSK: kind = mary_pkg::KIND_SINE;
			mary_pkg::MODE_PSK: kind = mary_pkg::KIND_SINE;
			default:            kind = mary_pkg::KIND_ZERO;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			j_q         <= '0;
			ask_phase_q <= '0;
			vld_s1      <= 1'b0;
		end else if (adv) begin
			vld_s1 <= emit;
			if (q_pop) begin
				busy_q <= 1'b1;
				j_q    <= '0;
			end else if (emit) begin
				if (last_smp) begin
					busy_q <= 1'b0;
				end else begin
					j_q <= j_q + 1'b1;
				end
			end
			if (emit) begin
				// carrier time restarts after the end of a message
				if (last_smp && mlast_q) begin
					ask_phase_q <= '0;
				end else if (cfg.mode == mary_pkg::MODE_ASK) begin
					ask_phase_q <= ask_phase_q + cfg.carrier_inc;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			if (q_pop) begin
				sym_q   <= q_data.sym;
				mlast_q <= q_data.last;
				acc_q   <= off_new;
				inc_q   <= inc_new;
			end else if (emit) begin
				acc_q <= acc_q + inc_q;
			end
			phase_s1     <= (cfg.mode == mary_pkg::MODE_ASK) ? ask_phase_q : acc_q;
			side_s1.sym  <= sym_q;
			side_s1.los  <= last_smp;
			side_s1.lom  <= last_smp && mlast_q;
			side_s1.kind <= kind;
		end
	end

	`MARY_CHECK_NOW(a_count_in_range, busy_q, (7'(j_q) < cfg.sps), "sample count past symbol length")
	`MARY_CHECK_NEXT(a_pop_starts_symbol, q_pop, (busy_q && j_q == '0), "symbol load did not start at sample zero")
	`MARY_CHECK_NEXT(a_ask_restart, (emit && last_smp && mlast_q), (ask_phase_q == '0), "carrier time not cleared at message end")

endmodule

// ----- hdl/mary_sine.sv -----
// Pipelined sine evaluator with ASK scaling, saturation and the output register.
// Depends on mary_pkg and mary_ifs.
module mary_sine #(
	parameter int unsigned SINE_TABLE_DEPTH = 1024,
	parameter int unsigned SINE_WIDTH       = 16
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            vld_s1,
	input  logic [31:0]     phase_s1,
	input  mary_pkg::side_t side_s1,
	output logic            adv,
	mary_smp_if.source      samples
);

	localparam int unsigned IDX_W = $clog2(SINE_TABLE_DEPTH);
	localparam int unsigned ZSH   = 32 - IDX_W;
	localparam logic [29:0] ZMASK = ~((30'd1 << ZSH) - 30'd1);
	localparam int unsigned RM_W  = 31 + SINE_WIDTH - 1;
	localparam int unsigned VR_W  = RM_W - 29;
	localparam int unsigned PW    = SINE_WIDTH + 5;
	localparam logic [SINE_WIDTH-2:0] AMP = '1;

	// stage 2: fold into the first quadrant, square
	logic [30:0]     z_c;
	logic            vld_s2;
	mary_pkg::side_t side_s2;
	logic [1:0]      quad_s2;
	logic [30:0]     z_s2;
	logic [60:0]     zsq_s2;

	// stages 3..7: Horner chain
	logic                vld_hs  [0:4];
	mary_pkg::side_t     side_hs [0:4];
	logic [1:0]          quad_hs [0:4];
	logic signed [32:0]  z_hs    [0:4];
	logic signed [32:0]  z2_hs   [0:4];
	logic signed [65:0]  m_hs    [0:4];
	logic signed [32:0]  z2_c;

	// stage 8: scale to amplitude
	logic signed [65:0]  r_w;
	logic [30:0]         r_c;
	logic                vld_s8;
	mary_pkg::side_t     side_s8;
	logic [1:0]          quad_s8;
	logic [RM_W-1:0]     rm_s8;

	// stage 9: round, sign, ASK product
	logic [RM_W:0]               rsum;
	logic [VR_W-1:0]             vr;
	logic [SINE_WIDTH-2:0]       vm;
	logic signed [SINE_WIDTH-1:0] vs;
	logic signed [SINE_WIDTH-1:0] vn;
	logic signed [4:0]           sym_sgn;
	logic signed [PW-1:0]        prod_c;
	logic                        vld_s9;
	mary_pkg::side_t             side_s9;
	logic signed [PW-1:0]        prod_s9;

	// stage 10: saturate into the output register
	logic signed [31:0] pw;
	logic               vld_s10;

	assign adv = !vld_s10 || samples.ready;

	assign z_c  = phase_s1[30] ? (31'h4000_0000 - {1'b0, phase_s1[29:0] & ZMASK})
	                           : {1'b0, phase_s1[29:0] & ZMASK};
	assign z2_c = $signed({2'b00, zsq_s2[60:30]});

	always_ff @(posedge clk) begin
		if (adv) begin
			side_s2 <= side_s1;
			quad_s2 <= phase_s1[31:30];
			z_s2    <= z_c;
			zsq_s2  <= 61'(z_c) * 61'(z_c);

			side_hs[0] <= side_s2;
			quad_hs[0] <= quad_s2;
			z_hs[0]    <= $signed({2'b00, z_s2});
			z2_hs[0]   <= z2_c;
			m_hs[0]    <= z2_c * mary_pkg::POLY_COEF[4];
		end
	end

	for (genvar h = 1; h <= 4; h++) begin : g_horner
		logic signed [32:0] t_c;
		logic signed [32:0] mop;
		assign t_c = mary_pkg::POLY_COEF[4-h] - 33'(m_hs[h-1] >>> 30);
		// last step multiplies by z instead of z squared
		assign mop = (h == 4) ? z_hs[h-1] : z2_hs[h-1];
		always_ff @(posedge clk) begin
			if (adv) begin
				side_hs[h] <= side_hs[h-1];
				quad_hs[h] <= quad_hs[h-1];
				z_hs[h]    <= z_hs[h-1];
				z2_hs[h]   <= z2_hs[h-1];
				m_hs[h]    <= mop * t_c;
			end
		end
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_hs[h] <= 1'b0;
			end else if (adv) begin
				vld_hs[h] <= vld_hs[h-1];
			end
		end
	end

	always_comb begin
		r_w     = m_hs[4] >>> 30;
		r_c     = (r_w < 0) ? 31'd0 : r_w[30:0];
		rsum    = {1'b0, rm_s8} + (RM_W+1)'(32'h2000_0000);
		vr      = rsum[RM_W:30];
		vm      = (vr > VR_W'(AMP)) ? AMP : vr[SINE_WIDTH-2:0];
		vs      = $signed({1'b0, vm});
		vn      = quad_s8[1] ? -vs : vs;
		sym_sgn = $signed({1'b0, side_s8.sym});
		case (side_s8.kind)
			mary_pkg::KIND_ASK:  prod_c = vn * sym_sgn;
			mary_pkg::KIND_SINE: prod_c = PW'(vn);
			default:             prod_c = '0;
		endcase
		pw = 32'(prod_s9);
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			side_s8 <= side_hs[4];
			quad_s8 <= quad_hs[4];
			rm_s8   <= RM_W'(r_c) * RM_W'(AMP);

			side_s9 <= side_s8;
			prod_s9 <= prod_c;

			if (pw > 32'sd524287) begin
				samples.sample <= 20'sd524287;
			end else if (pw < -32'sd524288) begin
				samples.sample <= -20'sd524288;
			end else begin
				samples.sample <= pw[19:0];
			end
			samples.symbol_value    <= side_s9.sym;
			samples.last_of_symbol  <= side_s9.los;
			samples.last_of_message <= side_s9.lom;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2    <= 1'b0;
			vld_hs[0] <= 1'b0;
			vld_s8    <= 1'b0;
			vld_s9    <= 1'b0;
			vld_s10   <= 1'b0;
		end else if (adv) begin
			vld_s2    <= vld_s1;
			vld_hs[0] <= vld_s2;
			vld_s8    <= vld_hs[4];
			vld_s9    <= vld_s8;
			vld_s10   <= vld_s9;
		end
	end

	assign samples.valid = vld_s10;

endmodule

// ----- hdl/mary_ask_fsk_psk_modulator_unit.sv -----
// Top level of the M-ary ASK/FSK/PSK modulator: configuration registers and the
// front end, symbol queue, sequencer and sine pipeline. Depends on mary_pkg and mary_ifs.

// Message bits enter one per item on "bits" and are packed MSB first into symbols of
// bits_per_symbol bits; the bit flagged last_bit closes the message and a short final
// symbol is padded with zeros at the low end. Every completed symbol emits
// samples_per_symbol items on "samples", one per cycle when the sink is ready. The front
// end takes a bit every cycle while the four-entry symbol queue has room, so bits keep
// flowing while a symbol is still being played out; the output side sustains one sample
// per clock while the sink is ready, set by the single sine pipeline; symbols follow each
// other with no gap. Each sample passes the sequencer register and nine sine stages ending
// in the output register. ASK carrier time runs on across a message and restarts at zero
// after its last sample; each symbol restarts FSK at phase zero and PSK at its phase
// offset. mod_mode 3 emits zero samples with normal timing. Write configuration over
// "cfg" only while no symbol is pending; writes land at once and never stall.
module mary_ask_fsk_psk_modulator_unit #(
	parameter int unsigned SINE_TABLE_DEPTH = 1024,
	parameter int unsigned SINE_WIDTH       = 16
) (
	input  logic       clk,
	input  logic       arst_n,
	mary_bit_if.sink   bits,
	mary_smp_if.source samples,
	mary_cfg_if.sink   cfg
);

	// raw register contents
	logic [1:0]  mod_mode_q;
	logic [2:0]  bps_q;
	logic [6:0]  sps_q;
	logic [31:0] carrier_inc_q;
	logic [31:0] fsk_inc_q;

	mary_pkg::mcfg_t      mcfg;
	logic                 q_push;
	mary_pkg::sym_entry_t q_wdata;
	logic                 q_full;
	logic                 q_pop;
	mary_pkg::sym_entry_t q_rdata;
	logic                 q_valid;
	logic                 adv;
	logic                 vld_s1;
	logic [31:0]          phase_s1;
	mary_pkg::side_t      side_s1;

	// writes never stall
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mod_mode_q    <= mary_pkg::MODE_ASK;
			bps_q         <= 3'd1;
			sps_q         <= 7'd10;
			carrier_inc_q <= '0;
			fsk_inc_q     <= '0;
		end else if (cfg.valid && cfg.ready) begin
			case (cfg.index)
				mary_pkg::REG_MOD_MODE:           mod_mode_q    <= cfg.data[1:0];
				mary_pkg::REG_BITS_PER_SYMBOL:    bps_q         <= cfg.data[2:0];
				mary_pkg::REG_SAMPLES_PER_SYMBOL: sps_q         <= cfg.data[6:0];
				mary_pkg::REG_CARRIER_PHASE_INC:  carrier_inc_q <= cfg.data;
				mary_pkg::REG_FSK_STEP_INC:       fsk_inc_q     <= cfg.data;
				default: ;
			endcase
		end
	end

	// clamp out-of-range settings: symbol size to 1..4 bits, length to 1..64 samples
	always_comb begin
		mcfg.mode        = mod_mode_q;
		mcfg.carrier_inc = carrier_inc_q;
		mcfg.fsk_inc     = fsk_inc_q;
		if (bps_q < mary_pkg::BPS_MIN) begin
			mcfg.bps = mary_pkg::BPS_MIN;
		end else if (bps_q > mary_pkg::BPS_MAX) begin
			mcfg.bps = mary_pkg::BPS_MAX;
		end else begin
			mcfg.bps = bps_q;
		end
		if (sps_q < mary_pkg::SPS_MIN) begin
			mcfg.sps = mary_pkg::SPS_MIN;
		end else if (sps_q > mary_pkg::SPS_MAX) begin
			mcfg.sps = mary_pkg::SPS_MAX;
		end else begin
			mcfg.sps = sps_q;
		end
	end

	// pack bits into symbols
	mary_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.bits   (bits),
		.cfg    (mcfg),
		.q_full (q_full),
		.q_push (q_push),
		.q_data (q_wdata)
	);

	// hold finished symbols so each side can stall on its own
	mary_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_data (q_wdata),
		.full      (q_full),
		.pop       (q_pop),
		.pop_data  (q_rdata),
		.not_empty (q_valid)
	);

	// advance phase per sample
	mary_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (mcfg),
		.q_valid  (q_valid),
		.q_data   (q_rdata),
		.q_pop    (q_pop),
		.adv      (adv),
		.vld_s1   (vld_s1),
		.phase_s1 (phase_s1),
		.side_s1  (side_s1)
	);

	// turn phase into the output sample
	mary_sine #(
		.SINE_TABLE_DEPTH (SINE_TABLE_DEPTH),
		.SINE_WIDTH       (SINE_WIDTH)
	) u_sine (
		.clk      (clk),
		.arst_n   (arst_n),
		.vld_s1   (vld_s1),
		.phase_s1 (phase_s1),
		.side_s1  (side_s1),
		.adv      (adv),
		.samples  (samples)
	);

endmodule

// ----- tb/tb.sv -----
// Testbench of the M-ary ASK/FSK/PSK modulator: directed and random bit streams
// against an in-bench sample predictor. Depends on mary_pkg and mary_ifs.
`timescale 1ns / 100ps

module tb;
	import mary_pkg::*;

	localparam int unsigned CLK_HALF     = 6;     // 12 ns period
	localparam int unsigned RESET_CYCLES = 5;
	// Leave slack for the sine pipeline and its output register to empty.
	localparam int unsigned DRAIN_CYCLES = 32;
	localparam int unsigned HOLD_CYCLES  = 400;   // long sink hold-off
	localparam int unsigned STALL_LIMIT  = 2000;  // cycles with no handshake at all
	localparam int unsigned RAND_PHASES  = 10;
	localparam int unsigned PHASE_BITS   = 36;

	localparam int unsigned TABLE_DEPTH = 1024;
	localparam int unsigned SINE_W      = 16;
	localparam longint      Q30_ONE     = longint'(1) <<< 30;
	localparam longint      SINE_AMP    = (longint'(1) <<< (SINE_W - 1)) - 1;

	// odd polynomial for sin(pi/2 * z), Q30
	localparam longint C1 = 64'sd1686629713;
	localparam longint C3 = 64'sd693598668;
	localparam longint C5 = 64'sd85569306;
	localparam longint C7 = 64'sd5026995;
	localparam longint C9 = 64'sd172271;

	localparam logic [1:0] MODE_UNUSED     = 2'd3;
	localparam logic [2:0] REG_UNMAPPED_LO = 3'd5;

	typedef struct packed {
		logic signed [19:0] sample;
		logic [3:0]         symbol_value;
		logic               los;
		logic               lom;
	} sample_rec_t;

	logic clk;
	logic arst_n;

	mary_bit_if bit_ch();
	mary_smp_if smp_ch();
	mary_cfg_if cfg_ch();

	mary_ask_fsk_psk_modulator_unit dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.bits    (bit_ch),
		.samples (smp_ch),
		.cfg     (cfg_ch)
	);

	// Predictor copy of the registers and of the symbol packer.
	logic [1:0]  cur_mode;
	logic [2:0]  cur_bps;
	logic [6:0]  cur_sps;
	logic [31:0] cur_carrier;
	logic [31:0] cur_fsk_step;
	logic [3:0]  gather;
	logic [2:0]  gathered;
	logic [31:0] ask_phase;

	sample_rec_t expected_samples[$];

	int unsigned fail_count   = 0;
	int unsigned quiet_cycles = 0;
	bit          tx_steady    = 1'b0;  // sender offers without gaps
	bit          rx_steady    = 1'b0;  // sink takes without gaps
	bit          hold_request = 1'b0;  // ask the sink for one long hold-off

	initial begin
		clk = 1'b0;
		forever #(CLK_HALF) clk = ~clk;
	end

	// Sine of a 32-bit phase (2^32 = one cycle), Q1.15, quadrant folded.
	function automatic longint sine_q15(input logic [31:0] ph);
		longint k, q4, quad, pos, z, z2, t, r, v;
		k    = (longint'(ph) * TABLE_DEPTH) >>> 32;
		q4   = k * 4;
		quad = q4 / TABLE_DEPTH;
		pos  = q4 - quad * TABLE_DEPTH;
		z    = (pos <<< 30) / TABLE_DEPTH;
		// mirror the position in the falling quadrants
		if (quad[0])
			z = Q30_ONE - z;
		z2 = (z * z) >>> 30;
		t  = C9;
		t  = C7 - ((z2 * t) >>> 30);
		t  = C5 - ((z2 * t) >>> 30);
		t  = C3 - ((z2 * t) >>> 30);
		t  = C1 - ((z2 * t) >>> 30);
		r  = (z * t) >>> 30;
		if (r < 0)
			r = 0;
		v = (r * SINE_AMP + (longint'(1) <<< 29)) >>> 30;
		if (v > SINE_AMP)
			v = SINE_AMP;
		if (quad >= 2)
			v = -v;
		return v;
	endfunction

	function automatic void reset_model();
		cur_mode     = MODE_ASK;
		cur_bps      = BPS_MIN;
		cur_sps      = 7'd10;
		cur_carrier  = '0;
		cur_fsk_step = '0;
		gather       = '0;
		gathered     = '0;
		ask_phase    = '0;
	endfunction

	function automatic void store_reg(input logic [2:0] idx, input logic [31:0] data);
		case (idx)
			REG_MOD_MODE:           cur_mode     = data[1:0];
			REG_BITS_PER_SYMBOL:    cur_bps      = data[2:0];
			REG_SAMPLES_PER_SYMBOL: cur_sps      = data[6:0];
			REG_CARRIER_PHASE_INC:  cur_carrier  = data;
			REG_FSK_STEP_INC:       cur_fsk_step = data;
			default: ;
		endcase
	endfunction

	// Pack one message bit; on a completed symbol queue its samples.
	function automatic void modulate_bit(input logic mbit, input logic lbit);
		int unsigned nb, ns;
		logic [3:0]  sym;
		logic [31:0] inc, offset, ph, step;
		longint      v;
		sample_rec_t rec;
		nb = (cur_bps < BPS_MIN) ? int'(BPS_MIN) :
			(cur_bps > BPS_MAX) ? int'(BPS_MAX) : int'(cur_bps);
		ns = (cur_sps < SPS_MIN) ? int'(SPS_MIN) :
			(cur_sps > SPS_MAX) ? int'(SPS_MAX) : int'(cur_sps);
		gather   = {gather[2:0], mbit};
		gathered = gathered + 3'd1;
		if (gathered < nb && !lbit)
			return;
		// pad a short closing symbol with zeros at the low end, keep the latest bits
		sym = gather;
		if (gathered < nb)
			sym = sym << (nb - gathered);
		sym      = sym & 4'((32'd1 << nb) - 32'd1);
		gather   = '0;
		gathered = '0;
		inc      = '0;
		offset   = '0;
		if (cur_mode == MODE_FSK) begin
			step = (32'(sym >> 1) + 32'd1) * cur_fsk_step;
			inc  = sym[0] ? cur_carrier + step : cur_carrier - step;
		end else if (cur_mode == MODE_PSK) begin
			inc = cur_carrier;
			if (nb == 1)
				offset = {sym[0], 31'd0};
			else
				offset = (32'(sym) * 32'd2 + 32'd1) << (31 - nb);
		end
		for (int unsigned j = 0; j < ns; j++) begin
			case (cur_mode)
				MODE_ASK: begin
					v = sine_q15(ask_phase) * longint'(sym);
					ask_phase = ask_phase + cur_carrier;
				end
				MODE_FSK, MODE_PSK: begin
					ph = 32'(j) * inc + offset;
					v  = sine_q15(ph);
				end
				default: v = 0;
			endcase
			if (v > 524287)
				v = 524287;
			if (v < -524288)
				v = -524288;
			rec.sample       = v[19:0];
			rec.symbol_value = sym;
			rec.los          = (j + 1 == ns);
			rec.lom          = lbit && (j + 1 == ns);
			expected_samples.insert(expected_samples.size(), rec);
		end
		// carrier time restarts with every new message
		if (lbit)
			ask_phase = '0;
	endfunction

	// Put random junk above a narrow register field.
	function automatic logic [31:0] pad_high(input logic [31:0] v, input int unsigned w);
		return ($urandom() << w) | v;
	endfunction

	task automatic write_reg(input logic [2:0] idx, input logic [31:0] data);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.data  <= data;
		@(posedge clk);
		while (!cfg_ch.ready)
			@(posedge clk);
		store_reg(idx, data);
		// drop valid after each write so back-to-back writes never collide
		cfg_ch.valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic set_config(input logic [1:0] mode, input logic [2:0] bps,
		input logic [6:0] sps, input logic [31:0] carrier, input logic [31:0] fsk_step);
		write_reg(REG_MOD_MODE, pad_high(32'(mode), 2));
		write_reg(REG_BITS_PER_SYMBOL, pad_high(32'(bps), 3));
		write_reg(REG_SAMPLES_PER_SYMBOL, pad_high(32'(sps), 7));
		write_reg(REG_CARRIER_PHASE_INC, carrier);
		write_reg(REG_FSK_STEP_INC, fsk_step);
	endtask

	// Offer one bit item, then predict its samples at the accepting edge.
	task automatic send_bit(input logic mbit, input logic lbit);
		int unsigned gap;
		gap = tx_steady ? 0 : $urandom_range(0, 4);
		if (gap != 0) begin
			bit_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		bit_ch.valid       <= 1'b1;
		bit_ch.message_bit <= mbit;
		bit_ch.last_bit    <= lbit;
		@(posedge clk);
		while (!bit_ch.ready)
			@(posedge clk);
		modulate_bit(mbit, lbit);
	endtask

	// Send count bits of pattern MSB first; flag the final one when closing.
	task automatic send_bits(input logic [31:0] pattern, input int unsigned count,
		input logic closing);
		for (int i = int'(count) - 1; i >= 0; i--)
			send_bit(pattern[i], closing && i == 0);
	endtask

	task automatic bits_done();
		bit_ch.valid <= 1'b0;
	endtask

	// Wait for every predicted sample, then let the pipeline settle.
	task automatic drain();
		while (expected_samples.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// Reset values: ASK, one bit per symbol, ten samples, carrier at zero.
	task automatic test_reset_defaults();
		send_bits(32'b10, 2, 1'b1);
		bits_done();
		drain();
	endtask

	// Largest symbol, then a short closing symbol padded to 4'b1000.
	task automatic test_ask();
		set_config(MODE_ASK, BPS_MAX, 7'd8, 32'h0800_0000, 32'h0);
		send_bits(32'b11111, 5, 1'b1);
		bits_done();
		drain();
	endtask

	// All four symbols of 4-FSK: both signs and both step multiples.
	task automatic test_fsk();
		set_config(MODE_FSK, 3'd2, 7'd16, 32'h1000_0000, 32'h0100_0000);
		send_bits(32'b00_01_10_11, 8, 1'b1);
		bits_done();
		drain();
	endtask

	// BPSK half-cycle offset, then 8-PSK at the largest symbol length.
	task automatic test_psk();
		set_config(MODE_PSK, BPS_MIN, 7'd4, 32'h0400_0000, 32'h0);
		send_bits(32'b01, 2, 1'b1);
		bits_done();
		drain();
		set_config(MODE_PSK, 3'd3, SPS_MAX, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		send_bits(32'b111, 3, 1'b1);
		bits_done();
		drain();
	endtask

	// Unmapped indexes, unused mode, and clamping of out-of-range sizes.
	task automatic test_odd_settings();
		for (int k = 0; k < 3; k++)
			write_reg(REG_UNMAPPED_LO + 3'(k), $urandom());
		set_config(MODE_UNUSED, 3'd0, 7'd0, $urandom(), $urandom());
		send_bits(32'b1, 1, 1'b1);
		bits_done();
		drain();
		set_config(MODE_PSK, 3'd7, 7'd127, 32'h0200_0000, 32'h0);
		send_bits(32'b10, 2, 1'b1);
		bits_done();
		drain();
	endtask

	// Lower the symbol size with three bits gathered: the next bit closes it.
	task automatic test_bps_lowered();
		set_config(MODE_FSK, BPS_MAX, 7'd4, 32'h0800_0000, 32'h0040_0000);
		send_bits(32'b101, 3, 1'b0);
		bits_done();
		drain();
		write_reg(REG_BITS_PER_SYMBOL, pad_high(32'(BPS_MIN), 3));
		send_bits(32'b1, 1, 1'b1);
		bits_done();
		drain();
	endtask

	// Hold the sink off for a long stretch while bits keep coming, so the
	// symbol queue fills and the input stalls.
	task automatic test_backpressure();
		set_config(MODE_ASK, BPS_MIN, SPS_MAX, $urandom(), 32'h0);
		tx_steady    = 1'b1;
		hold_request = 1'b1;
		send_bits($urandom(), 20, 1'b1);
		bits_done();
		tx_steady = 1'b0;
		drain();
	endtask

	// Random messages under a new setting per phase; the first two phases pin
	// the register extremes.
	task automatic test_random_messages();
		logic [1:0]  mode;
		logic [2:0]  bps;
		logic [6:0]  sps;
		logic [31:0] carrier, fsk_step;
		int unsigned sent, len;
		for (int unsigned p = 0; p < RAND_PHASES; p++) begin
			mode = ($urandom_range(0, 7) == 0) ? MODE_UNUSED :
				2'($urandom_range(MODE_ASK, MODE_PSK));
			if (p == 0) begin
				bps      = BPS_MIN;
				sps      = SPS_MIN;
				carrier  = 32'h0;
				fsk_step = 32'h0;
			end else if (p == 1) begin
				bps      = BPS_MAX;
				sps      = SPS_MAX;
				carrier  = 32'hFFFF_FFFF;
				fsk_step = 32'hFFFF_FFFF;
			end else begin
				bps = ($urandom_range(0, 3) == 0) ? 3'($urandom_range(0, 7)) :
					3'($urandom_range(BPS_MIN, BPS_MAX));
				case ($urandom_range(0, 9))
					0:       sps = 7'd0;
					1:       sps = SPS_MAX;
					2:       sps = 7'($urandom_range(65, 127));
					default: sps = 7'($urandom_range(1, 12));
				endcase
				carrier  = $urandom();
				fsk_step = $urandom_range(0, 1) ? $urandom() :
					$urandom() >> $urandom_range(4, 24);
			end
			set_config(mode, bps, sps, carrier, fsk_step);
			// vary the idling: some phases run flat out on one or both sides
			tx_steady = (p % 4 == 2) || (p % 4 == 3);
			rx_steady = (p % 4 == 3);
			sent = 0;
			while (sent < PHASE_BITS) begin
				len = $urandom_range(1, 24);
				// mostly closed messages; some run on into the next phase
				send_bits($urandom(), len, $urandom_range(0, 7) != 0);
				sent += len;
			end
			bits_done();
			drain();
		end
		tx_steady = 1'b0;
		rx_steady = 1'b0;
	endtask

	// Sink side: random ready gaps, one long hold-off on request.
	initial begin : sample_sink
		int unsigned gap;
		smp_ch.ready <= 1'b0;
		repeat (RESET_CYCLES) @(posedge clk);
		forever begin
			if (hold_request) begin
				hold_request = 1'b0;
				smp_ch.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end
			gap = rx_steady ? 0 : $urandom_range(0, 4);
			if (gap != 0) begin
				smp_ch.ready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			smp_ch.ready <= 1'b1;
			@(posedge clk);
			while (!smp_ch.valid)
				@(posedge clk);
		end
	end

	// Compare every accepted sample item with the oldest prediction.
	always @(posedge clk) begin : sample_check
		sample_rec_t want, got;
		if (arst_n && smp_ch.valid && smp_ch.ready) begin
			got = {smp_ch.sample, smp_ch.symbol_value, smp_ch.last_of_symbol,
				smp_ch.last_of_message};
			if (expected_samples.size() == 0) begin
				$display("%0t: unexpected sample %0d symbol %0d los %b lom %b", $time,
					got.sample, got.symbol_value, got.los, got.lom);
				fail_count++;
			end else begin
				want = expected_samples.pop_front();
				if (got !== want) begin
					$display("%0t: expected sample %0d symbol %0d los %b lom %b, got %0d %0d %b %b",
						$time, want.sample, want.symbol_value, want.los, want.lom,
						got.sample, got.symbol_value, got.los, got.lom);
					fail_count++;
				end
			end
		end
	end

	// Watchdog: abort when no channel moves an item for too long.
	always @(posedge clk) begin
		if (!arst_n || (bit_ch.valid && bit_ch.ready) || (smp_ch.valid && smp_ch.ready)
			|| (cfg_ch.valid && cfg_ch.ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= STALL_LIMIT) begin
			$display("%0t: no handshake for %0d cycles", $time, quiet_cycles);
			$display("Some tests failed");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin
		arst_n             <= 1'b0;
		bit_ch.valid       <= 1'b0;
		bit_ch.message_bit <= 1'b0;
		bit_ch.last_bit    <= 1'b0;
		cfg_ch.valid       <= 1'b0;
		cfg_ch.index       <= '0;
		cfg_ch.data        <= '0;
		reset_model();
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_defaults();
		test_ask();
		test_fsk();
		test_psk();
		test_odd_settings();
		test_bps_lowered();
		test_backpressure();
		test_random_messages();

		drain();
		if (fail_count == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
